FILE: src/assert_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/clnbs_pkg.sv
// Types and constants of the character display nibble bus sequencer.
package clnbs_pkg;

    localparam int unsigned WAIT_W     = 16;
    localparam int unsigned EW_W       = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_WAIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT_LONG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT_SHORT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_WIDTH    = 3'd4;

    localparam logic [WAIT_W-1:0] RST_POWER_UP_WAIT   = 16'd15000;
    localparam logic [WAIT_W-1:0] RST_INIT_WAIT_LONG  = 16'd5000;
    localparam logic [WAIT_W-1:0] RST_INIT_WAIT_SHORT = 16'd1000;
    localparam logic [WAIT_W-1:0] RST_CLEAR_WAIT      = 16'd10000;
    localparam logic [EW_W-1:0]   RST_ENABLE_WIDTH    = 8'd1;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSTR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    // request in progress
    localparam logic [2:0] RK_INIT     = 3'd0;
    localparam logic [2:0] RK_INSTR    = 3'd1;
    localparam logic [2:0] RK_DATA     = 3'd2;
    localparam logic [2:0] RK_POS      = 3'd3;
    localparam logic [2:0] RK_LINE_CLR = 3'd4;
    localparam logic [2:0] RK_FULL_CLR = 3'd5;

    localparam logic [7:0] NIB_INIT_8BIT = 8'h30;
    localparam logic [7:0] NIB_INIT_4BIT = 8'h20;
    localparam logic [7:0] INSTR_CLEAR   = 8'h01;
    localparam logic [7:0] ADDR_LINE1    = 8'h80;
    localparam logic [7:0] ADDR_LINE2    = 8'hC0;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [1:0] LINES_ALL     = 2'b11;
    localparam logic [1:0] LINE_FIRST    = 2'b01;

    localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h0C, 8'h06, 8'h01};

    typedef enum logic [7:0] {
        PH_PWR       = 8'b0000_0001,
        PH_INIT_WAIT = 8'b0000_0010,
        PH_CLR_WAIT  = 8'b0000_0100,
        PH_HI        = 8'b0000_1000,
        PH_LO        = 8'b0001_0000,
        PH_POLL_HI   = 8'b0010_0000,
        PH_POLL_LO   = 8'b0100_0000,
        PH_IDLE      = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [WAIT_W-1:0] power_up_wait;
        logic [WAIT_W-1:0] init_wait_long;
        logic [WAIT_W-1:0] init_wait_short;
        logic [WAIT_W-1:0] clear_wait;
        logic [EW_W-1:0]   enable_width;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        value;
        logic [1:0]        line_select;
        logic [5:0]        offset;
        logic              busy_sample;
    } t_item;

    typedef struct packed {
        logic       enable_pin;
        logic       select_data;
        logic       read_mode;
        logic [3:0] bus_nibble;
        logic       bus_drive;
        logic       ready_res;
        logic       rejected;
    } t_result;

endpackage

FILE: src/char_lcd_nibble_bus_sequencer_unit.sv
// Top level of the character display four-bit bus sequencer.
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tuser kind, tdata request fields
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata pin levels and flags, tuser select_data
//  cfg       in   i_cfg_we                          i_cfg_index, i_cfg_wdata
//
// One beat in gives one beat out; a beat can be taken every cycle while the result register is not stalled.
// A beat passes through the input register, then the sequencer step into the result register.
// The result register stalls the step and, through it, the input register.
// Synchronous reset puts the sequencer in the power-up wait and loads default registers.
`include "assert_macros.svh"

module char_lcd_nibble_bus_sequencer_unit #(
    parameter int unsigned LINE_CHARS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // value[7:0], line_select[9:8], offset[15:10], busy_sample[16], zero fill
    input  logic [clnbs_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // kind[2:0]
    input  logic [clnbs_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // enable_pin[0], read_mode[1], bus_nibble[5:2], bus_drive[6], ready_res[7],
    // rejected[8], zero fill
    output logic [clnbs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // select_data[0]
    output logic                                 o_m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [clnbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [clnbs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic               r_in_valid;
    clnbs_pkg::t_item   r_item;
    logic               r_out_valid;
    clnbs_pkg::t_result r_result;
    clnbs_pkg::t_result step_result;
    clnbs_pkg::t_cfg    cfg;
    logic               fire;
    logic               in_take;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.kind        <= i_s_axis_tuser;
            r_item.value       <= i_s_axis_tdata[7:0];
            r_item.line_select <= i_s_axis_tdata[9:8];
            r_item.offset      <= i_s_axis_tdata[15:10];
            r_item.busy_sample <= i_s_axis_tdata[16];
        end
    end

    clnbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    clnbs_fsm #(
        .LINE_CHARS (LINE_CHARS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_result.rejected, r_result.ready_res, r_result.bus_drive,
                              r_result.bus_nibble, r_result.read_mode, r_result.enable_pin};
    assign o_m_axis_tuser  = r_result.select_data;

    // a held input beat with a stalled result must block the slave side
    `ASSERT_IMPL(a_no_take_on_stall, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "beat taken while stalled")

endmodule

FILE: src/clnbs_cfg.sv
// Configuration register file of the sequencer.
module clnbs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [clnbs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clnbs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output clnbs_pkg::t_cfg                     o_cfg
);

    clnbs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_up_wait   <= clnbs_pkg::RST_POWER_UP_WAIT;
            r_cfg.init_wait_long  <= clnbs_pkg::RST_INIT_WAIT_LONG;
            r_cfg.init_wait_short <= clnbs_pkg::RST_INIT_WAIT_SHORT;
            r_cfg.clear_wait      <= clnbs_pkg::RST_CLEAR_WAIT;
            r_cfg.enable_width    <= clnbs_pkg::RST_ENABLE_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clnbs_pkg::CFG_POWER_UP_WAIT:   r_cfg.power_up_wait   <= i_cfg_wdata;
                clnbs_pkg::CFG_INIT_WAIT_LONG:  r_cfg.init_wait_long  <= i_cfg_wdata;
                clnbs_pkg::CFG_INIT_WAIT_SHORT: r_cfg.init_wait_short <= i_cfg_wdata;
                clnbs_pkg::CFG_CLEAR_WAIT:      r_cfg.clear_wait      <= i_cfg_wdata;
                clnbs_pkg::CFG_ENABLE_WIDTH: begin
                    r_cfg.enable_width <= i_cfg_wdata[clnbs_pkg::EW_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/clnbs_fsm.sv
// Bus sequencer state and per-tick next-state and pin logic.
`include "assert_macros.svh"

module clnbs_fsm #(
    parameter int unsigned LINE_CHARS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  clnbs_pkg::t_item   i_item,
    input  clnbs_pkg::t_cfg    i_cfg,
    output clnbs_pkg::t_result o_result
);

    localparam int unsigned CNT_W = $clog2(LINE_CHARS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LINE_CHARS);

    clnbs_pkg::t_phase r_phase, n_phase;
    logic [15:0]       r_dly, n_dly;
    logic [3:0]        r_init_step, n_init_step;
    logic [7:0]        r_byte_hold, n_byte_hold;
    logic              r_low_half, n_low_half;
    logic [CNT_W-1:0]  r_char_count, n_char_count;
    logic [1:0]        r_lines_pending, n_lines_pending;
    logic [2:0]        r_req_kind, n_req_kind;
    logic              r_data_sel, n_data_sel;
    logic              r_one_nibble, n_one_nibble;
    logic              r_busy_seen, n_busy_seen;

    logic [15:0]      ew_eff, dc_inc, dc_sat, wait_len, init_len;
    logic [3:0]       step_inc;
    logic [CNT_W-1:0] cc_inc;
    logic [3:0]       nib_cur;
    logic             st_byte, st_data, st_one, st_poll, st_idle;
    logic             wait_init, wait_clr, init_adv, next_line;
    logic [7:0]       st_val;
    logic [1:0]       lp_src;
    logic             request;

    assign ew_eff   = {8'd0, (i_cfg.enable_width == 8'd0) ? 8'd1 : i_cfg.enable_width};
    assign dc_inc   = r_dly + 16'd1;
    assign dc_sat   = (r_dly != 16'hFFFF) ? dc_inc : r_dly;
    assign step_inc = r_init_step + 4'd1;
    assign cc_inc   = r_char_count + CNT_W'(1);
    assign nib_cur  = r_low_half ? r_byte_hold[3:0] : r_byte_hold[7:4];
    assign request  = (i_item.kind >= clnbs_pkg::KIND_INSTR) &&
                      (i_item.kind <= clnbs_pkg::KIND_CLEAR);

    always_comb begin
        if (r_init_step == 4'd0) begin
            init_len = i_cfg.init_wait_long;
        end else if (r_init_step == 4'd2) begin
            init_len = 16'd0;
        end else begin
            init_len = i_cfg.init_wait_short;
        end
        if (r_phase == clnbs_pkg::PH_PWR) begin
            wait_len = i_cfg.power_up_wait;
        end else if (r_phase == clnbs_pkg::PH_CLR_WAIT) begin
            wait_len = i_cfg.clear_wait;
        end else begin
            wait_len = init_len;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_dly           = r_dly;
        n_init_step     = r_init_step;
        n_byte_hold     = r_byte_hold;
        n_low_half      = r_low_half;
        n_char_count    = r_char_count;
        n_lines_pending = r_lines_pending;
        n_req_kind      = r_req_kind;
        n_data_sel      = r_data_sel;
        n_one_nibble    = r_one_nibble;
        n_busy_seen     = r_busy_seen;
        st_byte   = 1'b0;
        st_val    = 8'd0;
        st_data   = 1'b0;
        st_one    = 1'b0;
        st_poll   = 1'b0;
        st_idle   = 1'b0;
        wait_init = 1'b0;
        wait_clr  = 1'b0;
        init_adv  = 1'b0;
        next_line = 1'b0;
        lp_src    = r_lines_pending;
        o_result  = '0;
        o_result.bus_drive = 1'b1;

        unique case (r_phase)
            clnbs_pkg::PH_HI: begin
                o_result.enable_pin  = 1'b1;
                o_result.select_data = r_data_sel;
                o_result.bus_nibble  = nib_cur;
                if (dc_inc >= ew_eff) begin
                    n_phase = clnbs_pkg::PH_LO;
                    n_dly   = 16'd0;
                end else begin
                    n_dly = dc_inc;
                end
            end
            clnbs_pkg::PH_LO: begin
                o_result.select_data = r_data_sel;
                o_result.bus_nibble  = nib_cur;
                if (!r_low_half && !r_one_nibble) begin
                    n_low_half = 1'b1;
                    n_dly      = 16'd0;
                    n_phase    = clnbs_pkg::PH_HI;
                end else begin
                    unique case (r_req_kind)
                        clnbs_pkg::RK_INIT: begin
                            if (r_init_step < 4'd4) begin
                                wait_init = 1'b1;
                            end else begin
                                n_init_step = step_inc;
                                if (step_inc >= 4'd4 && step_inc < 4'd8) begin
                                    st_byte = 1'b1;
                                    st_val  = clnbs_pkg::INIT_BYTES[step_inc[1:0]];
                                end else begin
                                    wait_clr = 1'b1;
                                end
                            end
                        end
                        clnbs_pkg::RK_LINE_CLR: begin
                            if (!r_data_sel) begin
                                n_char_count = '0;
                                st_poll      = 1'b1;
                            end else begin
                                n_char_count = cc_inc;
                                if (cc_inc < LAST_CNT) begin
                                    st_poll = 1'b1;
                                end else begin
                                    next_line = 1'b1;
                                end
                            end
                        end
                        clnbs_pkg::RK_FULL_CLR: wait_clr = 1'b1;
                        default:                st_idle  = 1'b1;
                    endcase
                end
            end
            clnbs_pkg::PH_POLL_HI: begin
                o_result.enable_pin = 1'b1;
                o_result.read_mode  = 1'b1;
                o_result.bus_drive  = 1'b0;
                if (dc_inc >= ew_eff) begin
                    n_busy_seen = i_item.busy_sample;
                    n_phase     = clnbs_pkg::PH_POLL_LO;
                    n_dly       = 16'd0;
                end else begin
                    n_dly = dc_inc;
                end
            end
            clnbs_pkg::PH_POLL_LO: begin
                o_result.read_mode = 1'b1;
                o_result.bus_drive = 1'b0;
                if (r_busy_seen) begin
                    st_poll = 1'b1;
                end else if (r_req_kind == clnbs_pkg::RK_DATA) begin
                    st_byte = 1'b1;
                    st_val  = r_byte_hold;
                    st_data = 1'b1;
                end else if (r_req_kind == clnbs_pkg::RK_LINE_CLR) begin
                    st_byte = 1'b1;
                    st_val  = clnbs_pkg::CHAR_SPACE;
                    st_data = 1'b1;
                end else begin
                    st_idle = 1'b1;
                end
            end
            clnbs_pkg::PH_PWR, clnbs_pkg::PH_INIT_WAIT, clnbs_pkg::PH_CLR_WAIT: begin
                if (dc_sat >= wait_len) begin
                    if (r_phase == clnbs_pkg::PH_PWR) begin
                        n_init_step = 4'd0;
                        st_byte     = 1'b1;
                        st_val      = clnbs_pkg::NIB_INIT_8BIT;
                        st_one      = 1'b1;
                    end else if (r_phase == clnbs_pkg::PH_INIT_WAIT) begin
                        init_adv = 1'b1;
                    end else begin
                        st_idle = 1'b1;
                    end
                end else begin
                    n_dly = dc_sat;
                end
            end
            clnbs_pkg::PH_IDLE: begin
                o_result.ready_res = 1'b1;
                unique case (i_item.kind)
                    clnbs_pkg::KIND_INSTR: begin
                        n_req_kind = clnbs_pkg::RK_INSTR;
                        st_byte    = 1'b1;
                        st_val     = i_item.value;
                    end
                    clnbs_pkg::KIND_DATA: begin
                        n_req_kind  = clnbs_pkg::RK_DATA;
                        n_byte_hold = i_item.value;
                        st_poll     = 1'b1;
                    end
                    clnbs_pkg::KIND_POS: begin
                        n_req_kind = clnbs_pkg::RK_POS;
                        st_byte    = 1'b1;
                        st_val     = ((i_item.line_select == clnbs_pkg::LINE_FIRST) ?
                                      clnbs_pkg::ADDR_LINE1 : clnbs_pkg::ADDR_LINE2) +
                                     {2'b00, i_item.offset};
                    end
                    clnbs_pkg::KIND_CLEAR: begin
                        if (i_item.line_select == clnbs_pkg::LINES_ALL) begin
                            n_req_kind = clnbs_pkg::RK_FULL_CLR;
                            st_byte    = 1'b1;
                            st_val     = clnbs_pkg::INSTR_CLEAR;
                        end else if (i_item.line_select != 2'b00) begin
                            n_req_kind = clnbs_pkg::RK_LINE_CLR;
                            lp_src     = i_item.line_select;
                            next_line  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: st_idle = 1'b1;
        endcase

        o_result.rejected = request && !o_result.ready_res;

        if (wait_init) begin
            if (init_len == 16'd0) begin
                init_adv = 1'b1;
            end else begin
                n_phase = clnbs_pkg::PH_INIT_WAIT;
                n_dly   = 16'd0;
            end
        end
        if (wait_clr) begin
            if (i_cfg.clear_wait == 16'd0) begin
                st_idle = 1'b1;
            end else begin
                n_phase = clnbs_pkg::PH_CLR_WAIT;
                n_dly   = 16'd0;
            end
        end
        if (init_adv) begin
            n_init_step = step_inc;
            st_byte     = 1'b1;
            if (step_inc < 4'd4) begin
                st_val = (step_inc < 4'd3) ? clnbs_pkg::NIB_INIT_8BIT : clnbs_pkg::NIB_INIT_4BIT;
                st_one = 1'b1;
            end else begin
                st_val = clnbs_pkg::INIT_BYTES[0];
            end
        end
        if (next_line) begin
            if (lp_src[0]) begin
                n_lines_pending = lp_src & 2'b10;
                st_byte         = 1'b1;
                st_val          = clnbs_pkg::ADDR_LINE1;
            end else if (lp_src[1]) begin
                n_lines_pending = 2'b00;
                st_byte         = 1'b1;
                st_val          = clnbs_pkg::ADDR_LINE2;
            end else begin
                st_idle = 1'b1;
            end
        end
        if (st_byte) begin
            n_byte_hold  = st_val;
            n_data_sel   = st_data;
            n_one_nibble = st_one;
            n_low_half   = 1'b0;
            n_dly        = 16'd0;
            n_phase      = clnbs_pkg::PH_HI;
        end
        if (st_poll) begin
            n_dly       = 16'd0;
            n_phase     = clnbs_pkg::PH_POLL_HI;
            n_busy_seen = 1'b0;
        end
        if (st_idle) begin
            n_phase    = clnbs_pkg::PH_IDLE;
            n_req_kind = clnbs_pkg::RK_INIT;
            n_dly      = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= clnbs_pkg::PH_PWR;
            r_dly           <= 16'd0;
            r_init_step     <= 4'd0;
            r_byte_hold     <= 8'd0;
            r_low_half      <= 1'b0;
            r_char_count    <= '0;
            r_lines_pending <= 2'b00;
            r_req_kind      <= clnbs_pkg::RK_INIT;
            r_data_sel      <= 1'b0;
            r_one_nibble    <= 1'b0;
            r_busy_seen     <= 1'b0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_dly           <= n_dly;
            r_init_step     <= n_init_step;
            r_byte_hold     <= n_byte_hold;
            r_low_half      <= n_low_half;
            r_char_count    <= n_char_count;
            r_lines_pending <= n_lines_pending;
            r_req_kind      <= n_req_kind;
            r_data_sel      <= n_data_sel;
            r_one_nibble    <= n_one_nibble;
            r_busy_seen     <= n_busy_seen;
        end
    end

    // second nibble only follows a full-byte write
    `ASSERT_IMPL(a_low_half_full_byte, i_clk, i_rst_n, r_low_half, !r_one_nibble, "low nibble of one-nibble write")
    // first line is always taken before the second
    `ASSERT_ALWAYS(a_lines_order, i_clk, i_rst_n, !r_lines_pending[0], "first line left pending")
    // lines are released only while reading the busy flag
    `ASSERT_IMPL(a_release_read, i_clk, i_rst_n, i_fire && !o_result.bus_drive, o_result.read_mode, "bus released in write")

endmodule
